>>> design/tawk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tawk_pkg: shared types and constants
// Field widths, block geometry and result record for the tar header walker.
// ----------------------------------------------------------------------------
package tawk_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned NAME_BYTES  = 100;
  localparam int unsigned SIZE_DIGITS = 11;
  localparam int unsigned SIZE_FIRST  = 124;

  localparam int unsigned POS_W    = $clog2(BLOCK_BYTES);
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NPOS_W   = 7;
  localparam int unsigned INDEX_W  = 24;
  localparam int unsigned SIZE_W   = 33;
  localparam int unsigned OFFSET_W = 40;
  localparam int unsigned BLKCNT_W = SIZE_W - POS_W;

  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(BLOCK_BYTES - 1);
  localparam logic [POS_W-1:0]  POS_NAME   = POS_W'(NAME_BYTES);
  localparam logic [POS_W-1:0]  POS_SIZE_0 = POS_W'(SIZE_FIRST);
  localparam logic [POS_W-1:0]  POS_SIZE_E = POS_W'(SIZE_FIRST + SIZE_DIGITS);
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

  // tdata: name_char, name_pos, entry_index, file_size, data_offset, bad_size
  localparam int unsigned RES_BITS = BYTE_W + NPOS_W + INDEX_W + SIZE_W + OFFSET_W + 1;
  localparam int unsigned OUT_W    = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    name_char;
    logic [NPOS_W-1:0]    name_pos;
    logic [INDEX_W-1:0]   entry_index;
    logic [SIZE_W-1:0]    file_size;
    logic [OFFSET_W-1:0]  data_offset;
    logic                 bad_size;
  } result_t;

endpackage

>>> design/tar_archive_header_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_archive_header_walker: ustar header walker
// Streams a tar archive byte by byte, emits name bytes, entry records and
// the end-of-archive count.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one archive byte per request in tdata; tuser high marks the first
//   byte of a new archive and restarts the walk from header byte 0.
//   m_axis: at most one result per byte; tuser gives the kind (name byte,
//   entry record, end of archive), tdata the record fields.
//   Path: an accepted byte waits in the input register, is parsed once the
//   output register is free, and its result is then held in the output register.
//   Throughput: one byte per cycle while no result stalls on the output, set by
//   the combinational parse step between the input register and the output register.
//   Bytes without a result (skipped fields, data blocks, after the end) pass
//   through even while a result waits on the output.
//   Stall: when m_axis_tready_i is low with a result waiting, a byte that would
//   produce a result holds in the input register and s_axis_tready_o drops.
//   Reset: walker returns to header byte 0 with zero entry count and offset;
//   both registers empty.
// ----------------------------------------------------------------------------
module tar_archive_header_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] data_byte
  input  logic                        s_axis_tuser_i,  // [0] archive_start
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] name_char, [14:8] name_pos, [38:15] entry_index,
  // [71:39] file_size, [111:72] data_offset, [112] bad_size, rest zero
  output logic [tawk_pkg::OUT_W-1:0]  m_axis_tdata_o,
  output logic [1:0]                  m_axis_tuser_o   // [1:0] kind
);
  import tawk_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_start_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  logic              out_free;
  logic              proc;
  logic              res_valid;
  result_t           res;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && (out_free || !res_valid);
  assign s_axis_tready_o = !in_valid_q || proc;

  tawk_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) in_valid_d = s_axis_tvalid_i;
    out_valid_d = out_valid_q;
    if (proc && res_valid)    out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
    if (proc && res_valid) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = OUT_W'({out_q.bad_size, out_q.data_offset, out_q.file_size,
                                   out_q.entry_index, out_q.name_pos, out_q.name_char});

endmodule

>>> design/tawk_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tawk_parser: per-byte header parser
// Holds the walk state and decodes one archive byte per enabled cycle.
// ----------------------------------------------------------------------------
module tawk_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [tawk_pkg::BYTE_W-1:0] byte_i,
  input  logic                       start_i,
  output logic                       res_valid_o,
  output tawk_pkg::result_t          res_o
);
  import tawk_pkg::*;

  logic [POS_W-1:0]    pos_q, pos_d;
  phase_e              phase_q, phase_d;
  logic [SIZE_W-1:0]   accum_q, accum_d;
  logic                bad_q, bad_d;
  logic [INDEX_W-1:0]  left_q, left_d;
  logic [INDEX_W-1:0]  count_q, count_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;

  logic [POS_W-1:0]    pos_e;
  phase_e              phase_e_w;
  logic [SIZE_W-1:0]   accum_e;
  logic                bad_e;
  logic [INDEX_W-1:0]  count_e;
  logic [OFFSET_W-1:0] offset_e;
  logic                last;
  logic                is_octal;
  logic [SIZE_W-1:0]   accum_m1;

  always_comb begin
    // start of a new archive overrides the stored state
    pos_e     = start_i ? '0 : pos_q;
    phase_e_w = start_i ? PH_HEADER : phase_q;
    count_e   = start_i ? '0 : count_q;
    offset_e  = start_i ? '0 : offset_q;
    accum_e   = (pos_e == '0) ? '0 : accum_q;
    bad_e     = (pos_e == '0) ? 1'b0 : bad_q;
    last      = (pos_e == POS_LAST);
    is_octal  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_SEVEN);
    accum_m1  = accum_e - SIZE_W'(1);

    pos_d       = last ? '0 : pos_e + POS_W'(1);
    phase_d     = phase_e_w;
    accum_d     = accum_e;
    bad_d       = bad_e;
    left_d      = left_q;
    count_d     = count_e;
    offset_d    = offset_e + OFFSET_W'(1);
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_NAME;

    unique case (phase_e_w)
      PH_HEADER: begin
        if (pos_e == '0 && byte_i == '0) begin
          phase_d           = PH_DONE;
          pos_d             = '0;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_END;
          res_o.entry_index = count_e;
        end else begin
          if (pos_e < POS_NAME) begin
            res_valid_o     = 1'b1;
            res_o.name_char = byte_i;
            res_o.name_pos  = pos_e[NPOS_W-1:0];
          end else if (pos_e >= POS_SIZE_0 && pos_e < POS_SIZE_E) begin
            // non-octal digit counts as zero
            accum_d = {accum_e[SIZE_W-4:0],
                       is_octal ? byte_i[2:0] : 3'd0};
            if (!is_octal) bad_d = 1'b1;
          end
          if (last) begin
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_ENTRY;
            res_o.entry_index = count_e;
            res_o.file_size   = accum_e;
            res_o.data_offset = offset_d;
            res_o.bad_size    = bad_e;
            if (count_e != '1) count_d = count_e + INDEX_W'(1);
            if (accum_e != '0) begin
              // whole data blocks after this one: ceil(size/512) - 1
              left_d  = accum_m1[SIZE_W-1:POS_W];
              phase_d = PH_DATA;
            end else begin
              left_d = '0;
            end
          end
        end
      end
      PH_DATA: begin
        if (last) begin
          if (left_q == '0) phase_d = PH_HEADER;
          else              left_d  = left_q - INDEX_W'(1);
        end
      end
      PH_DONE: begin
        pos_d = '0;
      end
      default: begin
        pos_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_HEADER;
      accum_q  <= '0;
      bad_q    <= 1'b0;
      left_q   <= '0;
      count_q  <= '0;
      offset_q <= '0;
    end else if (en_i) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      bad_q    <= bad_d;
      left_q   <= left_d;
      count_q  <= count_d;
      offset_q <= offset_d;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tar_archive_header_walker
// Streams a ustar-shaped archive (header, data block, end block) plus
// truncated headers, restarts and noise into the walker under random
// idling on both sides. A scoreboard predicts every name byte, entry record
// and end-of-archive count and checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tawk_pkg::*;

  localparam int NPOS_LO  = BYTE_W;
  localparam int INDEX_LO = NPOS_LO + NPOS_W;
  localparam int SIZE_LO  = INDEX_LO + INDEX_W;
  localparam int OFFS_LO  = SIZE_LO + SIZE_W;
  localparam int BAD_BIT  = OFFS_LO + OFFSET_W;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int TARGET_ITEMS    = 1200;

  typedef struct {
    kind_e                kind;
    logic [BYTE_W-1:0]    name_char;
    logic [NPOS_W-1:0]    name_pos;
    logic [INDEX_W-1:0]   entry_index;
    logic [SIZE_W-1:0]    file_size;
    logic [OFFSET_W-1:0]  data_offset;
    logic                 bad_size;
  } walk_result_t;

  class walk_scoreboard;
    walk_result_t         expected_q[$];
    int unsigned          errors;
    int unsigned          bytes_seen;
    int unsigned          results_seen;
    logic [POS_W-1:0]     byte_pos;
    phase_e               phase;
    logic [SIZE_W-1:0]    size_acc;
    logic                 size_bad;
    logic [INDEX_W-1:0]   blocks_left;
    logic [INDEX_W-1:0]   entry_count;
    logic [OFFSET_W-1:0]  offset;

    function new();
      errors       = 0;
      bytes_seen   = 0;
      results_seen = 0;
      restart();
    endfunction

    function void restart();
      byte_pos    = '0;
      phase       = PH_HEADER;
      size_acc    = '0;
      size_bad    = 1'b0;
      blocks_left = '0;
      entry_count = '0;
      offset      = '0;
    endfunction

    // Walk one accepted archive byte and queue the result it causes, if any.
    function void note_byte(input logic [7:0] b, input logic st);
      walk_result_t r;
      logic         last;
      logic [33:0]  blocks;
      logic [2:0]   digit;
      bytes_seen++;
      if (st) restart();
      r.kind        = KIND_NAME;
      r.name_char   = '0;
      r.name_pos    = '0;
      r.entry_index = '0;
      r.file_size   = '0;
      r.data_offset = '0;
      r.bad_size    = 1'b0;
      last   = (byte_pos == POS_LAST);
      offset = offset + 1'b1;
      case (phase)
        PH_HEADER: begin
          if (byte_pos == 0) begin
            size_acc = '0;
            size_bad = 1'b0;
            if (b == 0) begin
              // end-of-archive block: report count, ignore everything after
              phase         = PH_DONE;
              r.kind        = KIND_END;
              r.entry_index = entry_count;
              expected_q.push_back(r);
              byte_pos = '0;
              return;
            end
          end
          if (byte_pos < POS_NAME) begin
            r.kind      = KIND_NAME;
            r.name_char = b;
            r.name_pos  = byte_pos[NPOS_W-1:0];
            expected_q.push_back(r);
          end else if (byte_pos >= POS_SIZE_0 && byte_pos < POS_SIZE_E) begin
            if (b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
              digit = b[2:0];
            end else begin
              digit    = 3'd0;
              size_bad = 1'b1;
            end
            size_acc = {size_acc[SIZE_W-4:0], digit};
          end
          if (last) begin
            blocks        = ({1'b0, size_acc} + 34'(BLOCK_BYTES - 1)) >> POS_W;
            r.kind        = KIND_ENTRY;
            r.entry_index = entry_count;
            r.file_size   = size_acc;
            r.data_offset = offset;
            r.bad_size    = size_bad;
            expected_q.push_back(r);
            if (entry_count != {INDEX_W{1'b1}}) entry_count++;
            if (blocks != 0) begin
              blocks_left = INDEX_W'(blocks - 1);
              phase       = PH_DATA;
            end else begin
              blocks_left = '0;
            end
          end
        end
        PH_DATA: begin
          if (last) begin
            if (blocks_left == 0) phase = PH_HEADER;
            else blocks_left--;
          end
        end
        default: begin
          byte_pos = '0;
          return;
        end
      endcase
      byte_pos = last ? '0 : byte_pos + 1'b1;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task check_field(input string what, input logic [63:0] got, input logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", what, got, want));
    endtask

    task check_result(input logic [1:0] kind, input logic [OUT_W-1:0] data);
      walk_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, kind %0d", kind));
        return;
      end
      e = expected_q.pop_front();
      check_field("kind", 64'(kind), 64'(e.kind));
      check_field("name_char", 64'(data[0 +: BYTE_W]), 64'(e.name_char));
      check_field("name_pos", 64'(data[NPOS_LO +: NPOS_W]), 64'(e.name_pos));
      check_field("entry_index", 64'(data[INDEX_LO +: INDEX_W]), 64'(e.entry_index));
      check_field("file_size", 64'(data[SIZE_LO +: SIZE_W]), 64'(e.file_size));
      check_field("data_offset", 64'(data[OFFS_LO +: OFFSET_W]), 64'(e.data_offset));
      check_field("bad_size", 64'(data[BAD_BIT]), 64'(e.bad_size));
    endtask
  endclass

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               s_valid = 1'b0;
  logic [7:0]         s_data  = '0;
  logic               s_user  = 1'b0;
  logic               m_ready = 1'b0;
  logic               s_ready;
  logic               m_valid;
  logic [OUT_W-1:0]   m_data;
  logic [1:0]         m_user;
  int                 tx_mode = 1;
  int                 rx_mode = 1;
  walk_scoreboard     sb = new();

  always #1 clk_i = ~clk_i;

  tar_archive_header_walker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  // mode 0: no idling, 1: uniform 0..16, 2: mostly back to back
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = draw_gap(tx_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= st;
    do @(posedge clk_i); while (!s_ready);
    sb.note_byte(b, st);
  endtask

  // Hold off new requests until every queued result has been taken.
  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // bad_char < 0 picks a random non-octal character for each bad digit
  task automatic send_header(input logic [7:0] first, input logic [SIZE_W-1:0] size,
                             input int n_bad, input int bad_char, input logic st);
    logic [7:0] blk [BLOCK_BYTES];
    logic [7:0] c;
    int         k;
    for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = 8'($urandom);
    blk[0] = first;
    for (int i = 0; i < SIZE_DIGITS; i++)
      blk[SIZE_FIRST + i] = CHAR_ZERO | 8'((size >> (3 * (SIZE_DIGITS - 1 - i))) & 7);
    repeat (n_bad) begin
      k = $urandom_range(0, SIZE_DIGITS - 1);
      if (bad_char >= 0) begin
        c = 8'(bad_char);
      end else begin
        do c = 8'($urandom); while (c >= CHAR_ZERO && c <= CHAR_SEVEN);
      end
      blk[SIZE_FIRST + k] = c;
    end
    for (int i = 0; i < BLOCK_BYTES; i++) send_byte(blk[i], (i == 0) ? st : 1'b0);
  endtask

  task automatic send_junk(input int count, input int start_odds);
    repeat (count)
      send_byte(8'($urandom), (start_odds > 0) ? ($urandom_range(1, start_odds) == 1) : 1'b0);
  endtask

  // Header plus exactly the data blocks the parsed size calls for.
  task automatic send_entry(input logic [7:0] first, input logic [SIZE_W-1:0] size,
                            input int n_bad, input int bad_char, input logic st);
    send_header(first, size, n_bad, bad_char, st);
    if (sb.phase == PH_DATA) send_junk((sb.blocks_left + 1) * BLOCK_BYTES, 0);
  endtask

  task automatic send_end(input logic st, input int trailing);
    send_byte(8'h00, st);
    send_junk(trailing, 0);
  endtask

  task automatic send_truncated_header(input int count);
    send_byte(nonzero_byte(), 1'b1);
    send_junk(count - 1, 0);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk straight from reset: small entry with a non-octal size character,
    // then its data block unless that character wiped the only set digit
    tx_mode = 0;
    rx_mode = 0;
    send_entry(8'hFF, SIZE_W'(1), 1, 8'h38, 1'b0);
    // end of archive, bytes after it are dropped
    tx_mode = 1;
    rx_mode = 1;
    send_end(1'b0, 12);
    // restart in the middle of a header, then into an empty archive
    rx_mode = 2;
    send_truncated_header(150);
    send_end(1'b1, 5);
    drain();

    while (sb.bytes_seen < TARGET_ITEMS) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0:       send_junk($urandom_range(1, 30), 8);
        1:       send_truncated_header($urandom_range(1, 140));
        default: send_end(1'b1, $urandom_range(0, 20));
      endcase
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap(rx_mode);
      @(negedge clk_i);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (m_valid !== 1'b1);
      sb.check_result(m_user, m_data);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/tawk_pkg.sv
design/tawk_parser.sv
design/tar_archive_header_walker.sv
tb/testbench.sv
